/* rtl/core/cpr_pkg.sv */
// ============================================================================
// Camera pose rotation package
// Shared widths, constants, command codes and the CORDIC arctangent table.
// ============================================================================
`default_nettype none

package cpr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [31:0] EYE_Z_RST   = -32'sd327680;

    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_PITCH = 2'd1,
        KIND_YAW   = 2'd2,
        KIND_MOVE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DIR_FWD   = 2'd0,
        DIR_BACK  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RESET,
        OP_CORDIC_LOAD,
        OP_CORDIC_STEP,
        OP_CORDIC_DONE,
        OP_MUL,
        OP_MOVE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
    } cmd_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        case (i)
            5'd0:    atan_q28 = 32'sd210828714;
            5'd1:    atan_q28 = 32'sd124459457;
            5'd2:    atan_q28 = 32'sd65760959;
            5'd3:    atan_q28 = 32'sd33381290;
            5'd4:    atan_q28 = 32'sd16755422;
            5'd5:    atan_q28 = 32'sd8385879;
            5'd6:    atan_q28 = 32'sd4193963;
            5'd7:    atan_q28 = 32'sd2097109;
            5'd8:    atan_q28 = 32'sd1048571;
            5'd9:    atan_q28 = 32'sd524287;
            5'd10:   atan_q28 = 32'sd262144;
            5'd11:   atan_q28 = 32'sd131072;
            5'd12:   atan_q28 = 32'sd65536;
            5'd13:   atan_q28 = 32'sd32768;
            5'd14:   atan_q28 = 32'sd16384;
            5'd15:   atan_q28 = 32'sd8192;
            5'd16:   atan_q28 = 32'sd4096;
            5'd17:   atan_q28 = 32'sd2048;
            5'd18:   atan_q28 = 32'sd1024;
            5'd19:   atan_q28 = 32'sd512;
            5'd20:   atan_q28 = 32'sd256;
            5'd21:   atan_q28 = 32'sd128;
            5'd22:   atan_q28 = 32'sd64;
            5'd23:   atan_q28 = 32'sd32;
            default: atan_q28 = 32'sd0;
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            sat16 = 16'sh7fff;
        else if (v < -48'sd32768)
            sat16 = 16'sh8000;
        else
            sat16 = v[15:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cpr_ctrl.sv */
// ============================================================================
// Camera pose controller
// Sequences reset, CORDIC iterations, shared multiply steps and move updates.
// ============================================================================
`default_nettype none

module cpr_ctrl
    import cpr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic  [1:0] kind,
    input  wire logic  out_fire,
    output logic       busy,
    output logic       out_valid,
    output cmd_t       cmd
);

    localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    // Pitch: 9 matrix products, 6 scaled, 9 forward terms, 6 cross. Yaw: 6.
    localparam int PITCH_OPS = 30;
    localparam int YAW_OPS   = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOAD,
        S_CSTEP,
        S_CDONE,
        S_MUL,
        S_OUT
    } state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic       pitch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pitch_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        pitch_reg <= (kind == KIND_PITCH);
                        cnt_reg   <= '0;
                        if (kind == KIND_PITCH || kind == KIND_YAW)
                            state_reg <= S_CLOAD;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_CLOAD:
                    state_reg <= S_CSTEP;
                S_CSTEP:
                begin
                    if (cnt_reg == 5'(NSTEP - 1))
                        state_reg <= S_CDONE;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_CDONE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if ((pitch_reg && cnt_reg == 5'(PITCH_OPS - 1)) ||
                        (!pitch_reg && cnt_reg == 5'(YAW_OPS - 1)))
                        state_reg <= S_OUT;
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_OUT:
                begin
                    if (out_fire)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.idx = cnt_reg;
        cmd.op  = OP_NONE;
        if (state_reg == S_IDLE && in_fire)
        begin
            if (kind == KIND_RESET)
                cmd.op = OP_RESET;
            else if (kind == KIND_MOVE)
                cmd.op = OP_MOVE;
        end
        else if (state_reg == S_CLOAD)
            cmd.op = OP_CORDIC_LOAD;
        else if (state_reg == S_CSTEP)
            cmd.op = OP_CORDIC_STEP;
        else if (state_reg == S_CDONE)
            cmd.op = OP_CORDIC_DONE;
        else if (state_reg == S_MUL)
            cmd.op = OP_MUL;
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_fire |=> out_valid)
        else $error("result dropped before it was taken");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_fire)
        else $error("word accepted while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CSTEP |-> cnt_reg < 5'(NSTEP))
        else $error("CORDIC step count overrun");
`endif

endmodule

`default_nettype wire

/* rtl/core/cpr_dp.sv */
// ============================================================================
// Camera pose datapath
// Pose registers, iterative CORDIC and one shared 32x32 multiplier.
// ============================================================================
`default_nettype none

module cpr_dp
    import cpr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cmd_t       cmd,
    input  wire logic  [1:0] kind,
    input  wire logic  signed [15:0] angle,
    input  wire logic  [1:0] direction,
    input  wire logic  signed [31:0] amount,
    output logic signed [31:0] eye [3],
    output logic signed [15:0] rgt [3],
    output logic signed [15:0] upv [3],
    output logic signed [15:0] fwd [3]
);

    logic signed [31:0] eye_reg [3];
    logic signed [15:0] rgt_reg [3];
    logic signed [15:0] up_reg  [3];
    logic signed [15:0] fwd_reg [3];

    logic               pitch_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [17:0] s_reg, c_reg;
    // Scratch: matrix products (9), then matrix elements (9), forward sums.
    logic signed [31:0] q_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [47:0] acc_reg;
    logic signed [15:0] nf_reg [3];

    // Angle range reduction.
    logic signed [33:0] z0, z1, z2;
    logic               neg0;
    always_comb
    begin
        z0 = 34'(angle) <<< 16;
        if (z0 > 34'(PI_Q28))
            z1 = z0 - 34'(PI_Q28) - 34'(PI_Q28);
        else if (z0 < -34'(PI_Q28))
            z1 = z0 + 34'(PI_Q28) + 34'(PI_Q28);
        else
            z1 = z0;
        neg0 = 1'b0;
        if (z1 > 34'(HALF_PI_Q28))
        begin
            z2 = z1 - 34'(PI_Q28);
            neg0 = 1'b1;
        end
        else if (z1 < -34'(HALF_PI_Q28))
        begin
            z2 = z1 + 34'(PI_Q28);
            neg0 = 1'b1;
        end
        else
            z2 = z1;
    end

    logic signed [33:0] xs, ys;
    assign xs = cx_reg >>> cmd.idx;
    assign ys = cy_reg >>> cmd.idx;

    logic signed [33:0] cr, sr;
    assign cr = (cx_reg + 34'sd8192) >>> 14;
    assign sr = (cy_reg + 34'sd8192) >>> 14;

    // Operand selection for the shared multiplier.
    logic signed [31:0] ma, mb, madd;
    logic signed [31:0] oc;
    logic [1:0]         i3, j3;
    assign oc = 32'(ONE_Q14) - 32'(c_reg);

    // Row and column of the forward-transform step.
    always_comb
    begin
        case (cmd.idx)
            5'd15:   begin i3 = 2'd0; j3 = 2'd0; end
            5'd16:   begin i3 = 2'd0; j3 = 2'd1; end
            5'd17:   begin i3 = 2'd0; j3 = 2'd2; end
            5'd18:   begin i3 = 2'd1; j3 = 2'd0; end
            5'd19:   begin i3 = 2'd1; j3 = 2'd1; end
            5'd20:   begin i3 = 2'd1; j3 = 2'd2; end
            5'd21:   begin i3 = 2'd2; j3 = 2'd0; end
            5'd22:   begin i3 = 2'd2; j3 = 2'd1; end
            5'd23:   begin i3 = 2'd2; j3 = 2'd2; end
            default: begin i3 = 2'd0; j3 = 2'd0; end
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        madd = '0;
        if (pitch_reg)
        begin
            if (cmd.idx < 5'd9)
            begin
                // q = products a_i*a_j for the symmetric pairs, then a_i*s.
                case (cmd.idx)
                    5'd0: begin ma = 32'(rgt_reg[0]); mb = 32'(rgt_reg[0]); end
                    5'd1: begin ma = 32'(rgt_reg[0]); mb = 32'(rgt_reg[1]); end
                    5'd2: begin ma = 32'(rgt_reg[0]); mb = 32'(rgt_reg[2]); end
                    5'd3: begin ma = 32'(rgt_reg[1]); mb = 32'(rgt_reg[1]); end
                    5'd4: begin ma = 32'(rgt_reg[1]); mb = 32'(rgt_reg[2]); end
                    5'd5: begin ma = 32'(rgt_reg[2]); mb = 32'(rgt_reg[2]); end
                    5'd6: begin ma = 32'(rgt_reg[0]); mb = 32'(s_reg); end
                    5'd7: begin ma = 32'(rgt_reg[1]); mb = 32'(s_reg); end
                    default: begin ma = 32'(rgt_reg[2]); mb = 32'(s_reg); end
                endcase
            end
            else if (cmd.idx < 5'd15)
            begin
                ma = q_reg[4'(cmd.idx - 5'd9)];
                mb = oc;
            end
            else if (cmd.idx < 5'd24)
            begin
                ma = m_reg[4'(i3) * 4'd3 + 4'(j3)];
                mb = 32'(fwd_reg[j3]);
            end
            else
            begin
                // Cross product terms: even index first product, odd second.
                case (cmd.idx)
                    5'd24: begin ma = 32'(nf_reg[1]); mb = 32'(rgt_reg[2]); end
                    5'd25: begin ma = 32'(nf_reg[2]); mb = 32'(rgt_reg[1]); end
                    5'd26: begin ma = 32'(nf_reg[2]); mb = 32'(rgt_reg[0]); end
                    5'd27: begin ma = 32'(nf_reg[0]); mb = 32'(rgt_reg[2]); end
                    5'd28: begin ma = 32'(nf_reg[0]); mb = 32'(rgt_reg[1]); end
                    default: begin ma = 32'(nf_reg[1]); mb = 32'(rgt_reg[0]); end
                endcase
            end
        end
        else
        begin
            // Yaw: per axis, new x on the even step, then new z on the odd step (sum, then difference).
            case (cmd.idx[2:1])
                2'd0: begin ma = 32'(fwd_reg[0]); madd = 32'(fwd_reg[2]); end
                2'd1: begin ma = 32'(up_reg[0]);  madd = 32'(up_reg[2]);  end
                default: begin ma = 32'(rgt_reg[0]); madd = 32'(rgt_reg[2]); end
            endcase
            mb = 32'(c_reg);
        end
    end

    // One 32x32 product per cycle; yaw adds narrow 16x18 products (one on even steps, two on odd).
    logic signed [63:0] prod;
    logic signed [47:0] prod2;
    logic signed [47:0] yaw_sum;
    logic signed [31:0] p14;
    always_comb
    begin
        prod  = 64'(ma) * 64'(mb);
        prod2 = 48'(madd) * 48'(s_reg);
        if (!cmd.idx[0])
            yaw_sum = 48'(prod) + prod2;
        else
            yaw_sum = 48'(madd) * 48'(c_reg) - 48'(ma) * 48'(s_reg);
        p14 = 32'((prod + 64'sd8192) >>> 14);
    end

    logic signed [63:0] mv_prod [3];
    logic signed [63:0] mv_sum  [3];
    logic signed [15:0] mv_ax   [3];
    logic               mv_sub;
    always_comb
    begin
        mv_sub = (direction == DIR_BACK) || (direction == DIR_LEFT);
        for (int k = 0; k < 3; k++)
        begin
            mv_ax[k]   = (direction == DIR_FWD || direction == DIR_BACK) ?
                         fwd_reg[k] : rgt_reg[k];
            mv_prod[k] = (64'(mv_ax[k]) * 64'(amount) + 64'sd8192) >>> 14;
            mv_sum[k]  = mv_sub ? 64'(eye_reg[k]) - mv_prod[k] :
                                  64'(eye_reg[k]) + mv_prod[k];
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    logic signed [47:0] yaw_r;
    assign yaw_r = (yaw_sum + 48'sd8192) >>> 14;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg <= '{32'sd0, 32'sd0, EYE_Z_RST};
            rgt_reg <= '{ONE_Q14, 16'sd0, 16'sd0};
            up_reg  <= '{16'sd0, ONE_Q14, 16'sd0};
            fwd_reg <= '{16'sd0, 16'sd0, ONE_Q14};
            pitch_reg <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            neg_reg   <= 1'b0;
            s_reg     <= '0;
            c_reg     <= '0;
            q_reg     <= '{default: '0};
            m_reg     <= '{default: '0};
            acc_reg   <= '0;
            nf_reg    <= '{default: '0};
        end
        else
        begin
            case (cmd.op)
                OP_RESET:
                begin
                    eye_reg <= '{32'sd0, 32'sd0, EYE_Z_RST};
                    rgt_reg <= '{ONE_Q14, 16'sd0, 16'sd0};
                    up_reg  <= '{16'sd0, ONE_Q14, 16'sd0};
                    fwd_reg <= '{16'sd0, 16'sd0, ONE_Q14};
                end
                OP_MOVE:
                begin
                    for (int k = 0; k < 3; k++)
                        eye_reg[k] <= sat32(mv_sum[k]);
                end
                OP_CORDIC_LOAD:
                begin
                    pitch_reg <= (kind == KIND_PITCH);
                    cx_reg    <= 34'(GAIN_Q28);
                    cy_reg    <= '0;
                    cz_reg    <= z2;
                    neg_reg   <= neg0;
                end
                OP_CORDIC_STEP:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - 34'(atan_q28(cmd.idx));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + 34'(atan_q28(cmd.idx));
                    end
                end
                OP_CORDIC_DONE:
                begin
                    c_reg <= neg_reg ? -18'(cr) : 18'(cr);
                    s_reg <= neg_reg ? -18'(sr) : 18'(sr);
                end
                OP_MUL:
                begin
                    if (pitch_reg)
                    begin
                        if (cmd.idx < 5'd9)
                            q_reg[4'(cmd.idx)] <= p14;
                        else if (cmd.idx < 5'd15)
                        begin
                            // Build matrix once the scaled product is known.
                            case (cmd.idx)
                                5'd9:  m_reg[0] <= p14 + 32'(c_reg);
                                5'd10:
                                begin
                                    m_reg[1] <= p14 + q_reg[8];
                                    m_reg[3] <= p14 - q_reg[8];
                                end
                                5'd11:
                                begin
                                    m_reg[2] <= p14 - q_reg[7];
                                    m_reg[6] <= p14 + q_reg[7];
                                end
                                5'd12: m_reg[4] <= p14 + 32'(c_reg);
                                5'd13:
                                begin
                                    m_reg[5] <= p14 + q_reg[6];
                                    m_reg[7] <= p14 - q_reg[6];
                                end
                                default: m_reg[8] <= p14 + 32'(c_reg);
                            endcase
                        end
                        else if (cmd.idx < 5'd24)
                        begin
                            if (j3 == 2'd2)
                            begin
                                nf_reg[i3] <= sat16(acc_reg + 48'(p14));
                                acc_reg    <= '0;
                            end
                            else if (j3 == 2'd0)
                                acc_reg <= 48'(p14);
                            else
                                acc_reg <= acc_reg + 48'(p14);
                        end
                        else if (!cmd.idx[0])
                        begin
                            acc_reg <= 48'(prod);
                            if (cmd.idx == 5'd24)
                                fwd_reg <= nf_reg;
                        end
                        else
                        begin
                            case (cmd.idx)
                                5'd25: up_reg[0] <=
                                    sat16((acc_reg - 48'(prod) + 48'sd8192) >>> 14);
                                5'd27: up_reg[1] <=
                                    sat16((acc_reg - 48'(prod) + 48'sd8192) >>> 14);
                                default: up_reg[2] <=
                                    sat16((acc_reg - 48'(prod) + 48'sd8192) >>> 14);
                            endcase
                        end
                    end
                    else
                    begin
                        case (cmd.idx[2:1])
                            2'd0:
                                if (!cmd.idx[0]) acc_reg <= yaw_r;
                                else
                                begin
                                    fwd_reg[0] <= sat16(acc_reg);
                                    fwd_reg[2] <= sat16(yaw_r);
                                end
                            2'd1:
                                if (!cmd.idx[0]) acc_reg <= yaw_r;
                                else
                                begin
                                    up_reg[0] <= sat16(acc_reg);
                                    up_reg[2] <= sat16(yaw_r);
                                end
                            default:
                                if (!cmd.idx[0]) acc_reg <= yaw_r;
                                else
                                begin
                                    rgt_reg[0] <= sat16(acc_reg);
                                    rgt_reg[2] <= sat16(yaw_r);
                                end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign eye = eye_reg;
    assign rgt = rgt_reg;
    assign upv = up_reg;
    assign fwd = fwd_reg;

endmodule

`default_nettype wire

/* rtl/core/camera_pose_rotation_unit.sv */
// Reset and move update the pose when accepted and the result word follows
// in the next cycle; yaw and pitch first run the iterative CORDIC and then
// the multiply steps on the single shared multiplier.
// One command is in flight at a time; the next is accepted after the result
// word is taken. Reset is asynchronous and restores the home pose.
// ============================================================================
// Camera pose rotation unit
// Fly-camera pose keeper with pitch, yaw, move and reset commands.
// ============================================================================
`default_nettype none

module camera_pose_rotation_unit
    import cpr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // angle[15:0], direction[17:16], amount[49:18], zero pad to 56
    input  wire logic [55:0]  s_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // eye_x, eye_y, eye_z (32 each), then right, up, fwd xyz (16 each)
    output logic [239:0]      m_tdata
);

    cmd_t cmd;
    logic busy, in_fire, out_fire;
    logic signed [31:0] eye [3];
    logic signed [15:0] rgt [3];
    logic signed [15:0] upv [3];
    logic signed [15:0] fwd [3];
    logic [1:0] kind_reg;
    logic signed [15:0] angle_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // The angle is held here because the CORDIC loads it in the cycle after accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_RESET;
            angle_reg <= '0;
        end
        else if (in_fire)
        begin
            kind_reg  <= s_tuser;
            angle_reg <= $signed(s_tdata[15:0]);
        end
    end

    cpr_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .kind(s_tuser),
        .out_fire(out_fire), .busy(busy), .out_valid(m_tvalid), .cmd(cmd)
    );

    cpr_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .kind(kind_reg),
        .angle(angle_reg), .direction(s_tdata[17:16]),
        .amount(s_tdata[49:18]),
        .eye(eye), .rgt(rgt), .upv(upv), .fwd(fwd)
    );

    assign m_tdata = {fwd[2], fwd[1], fwd[0], upv[2], upv[1], upv[0],
                      rgt[2], rgt[1], rgt[0], eye[2], eye[1], eye[0]};

endmodule

`default_nettype wire
